// ----- rtl/c8ie_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types and constants of the CHIP-8 instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

	localparam int ADDR_W            = 12;
	localparam int STACK_ENTRIES_DEF = 16;
	localparam int QUEUE_DEPTH       = 2;
	localparam logic [ADDR_W-1:0] START_DEFAULT = 12'h200;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_UNHANDLED = 2'd3
	} status_t;

	// Instruction classes resolved by the front end
	typedef enum logic [3:0] {
		OP_CLS,
		OP_RET,
		OP_JP,
		OP_CALL,
		OP_SE_IMM,
		OP_SNE_IMM,
		OP_SE_REG,
		OP_SNE_REG,
		OP_LD_IMM,
		OP_ADD_IMM,
		OP_ALU,
		OP_LD_I,
		OP_JP_V0,
		OP_RND,
		OP_UNHANDLED
	} op_class_t;

	// 8XYn sub-operations, coded by the low nibble
	typedef enum logic [3:0] {
		ALU_MOV  = 4'h0,
		ALU_OR   = 4'h1,
		ALU_AND  = 4'h2,
		ALU_XOR  = 4'h3,
		ALU_ADD  = 4'h4,
		ALU_SUB  = 4'h5,
		ALU_SHR  = 4'h6,
		ALU_SUBN = 4'h7,
		ALU_SHL  = 4'hE
	} alu_op_t;

	typedef struct packed {
		logic [15:0] instruction;
		logic [7:0]  random_byte;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] next_pc;
		logic [ADDR_W-1:0] index_value;
		logic              write_enable;
		logic [3:0]        write_reg;
		logic [7:0]        write_value;
		logic [7:0]        flag_value;
		logic              clear_screen;
		status_t           status;
	} out_item_t;

	// Classified instruction as held in the queue
	typedef struct packed {
		op_class_t         cls;
		alu_op_t           alu;
		logic [3:0]        x;
		logic [3:0]        y;
		logic [ADDR_W-1:0] nnn;
		logic [7:0]        rnd;
	} dec_t;

endpackage

// ----- rtl/c8ie_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_front
// Accepts instruction requests and registers them in classified form.
// ----------------------------------------------------------------------------
module c8ie_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  c8ie_pkg::in_item_t in_data,
	output logic               push_valid,
	input  logic               push_ready,
	output c8ie_pkg::dec_t     push_data
);
	import c8ie_pkg::*;

	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SE   = 4'h3;
	localparam logic [3:0] GRP_SNE  = 4'h4;
	localparam logic [3:0] GRP_SER  = 4'h5;
	localparam logic [3:0] GRP_LD   = 4'h6;
	localparam logic [3:0] GRP_ADD  = 4'h7;
	localparam logic [3:0] GRP_ALU  = 4'h8;
	localparam logic [3:0] GRP_SNER = 4'h9;
	localparam logic [3:0] GRP_LDI  = 4'hA;
	localparam logic [3:0] GRP_JPV0 = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;

	localparam logic [15:0] INSTR_CLS = 16'h00E0;
	localparam logic [15:0] INSTR_RET = 16'h00EE;

	logic        vld_s1;
	dec_t        dec_s1;
	dec_t        dec;
	logic [15:0] ins;

	assign ins = in_data.instruction;

	// Classify the incoming instruction
	always_comb begin
		dec.x   = ins[11:8];
		dec.y   = ins[7:4];
		dec.nnn = ins[11:0];
		dec.rnd = in_data.random_byte;
		dec.alu = alu_op_t'(ins[3:0]);
		case (ins[15:12])
			GRP_SYS: begin
				if (ins == INSTR_CLS)
					dec.cls = OP_CLS;
				else if (ins == INSTR_RET)
					dec.cls = OP_RET;
				else
					dec.cls = OP_UNHANDLED;
			end
			GRP_JP:   dec.cls = OP_JP;
			GRP_CALL: dec.cls = OP_CALL;
			GRP_SE:   dec.cls = OP_SE_IMM;
			GRP_SNE:  dec.cls = OP_SNE_IMM;
			GRP_SER:  dec.cls = OP_SE_REG;
			GRP_LD:   dec.cls = OP_LD_IMM;
			GRP_ADD:  dec.cls = OP_ADD_IMM;
			GRP_ALU: begin
				case (dec.alu)
					ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
					ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: dec.cls = OP_ALU;
					default: dec.cls = OP_UNHANDLED;
				endcase
			end
			GRP_SNER: dec.cls = OP_SNE_REG;
			GRP_LDI:  dec.cls = OP_LD_I;
			GRP_JPV0: dec.cls = OP_JP_V0;
			GRP_RND:  dec.cls = OP_RND;
			default:  dec.cls = OP_UNHANDLED;
		endcase
	end

	// Hold a request until the queue takes it
	assign in_ready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_data  = dec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1 <= dec;
		end
	end

endmodule

// ----- rtl/c8ie_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_queue
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module c8ie_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  c8ie_pkg::dec_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output c8ie_pkg::dec_t pop_data
);
	import c8ie_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	dec_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign pop_valid  = (count_q != '0);
	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH)) || pop_ready;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/c8ie_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8ie_back
// Reads operands, executes one instruction per cycle while the output is not stalled and holds the result.
// ----------------------------------------------------------------------------
module c8ie_back #(
	parameter int STACK_ENTRIES = c8ie_pkg::STACK_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  c8ie_pkg::dec_t              pop_data,
	input  logic                        cfg_we,
	input  logic [c8ie_pkg::ADDR_W-1:0] cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output c8ie_pkg::out_item_t         out_data
);
	import c8ie_pkg::*;

	localparam int SIDX_W = $clog2(STACK_ENTRIES);
	localparam int CNT_W  = $clog2(STACK_ENTRIES + 1);
	localparam logic [3:0] REG_V0 = 4'h0;
	localparam logic [3:0] REG_VF = 4'hF;

	// Operand stage
	logic              valid_s2;
	dec_t              dec_s2;
	logic [7:0]        vx_s2;
	logic [7:0]        vy_s2;

	// Architectural state
	logic [ADDR_W-1:0] pc_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        v0_q;
	logic [7:0]        vf_q;
	logic [15:0]       vld_q;
	logic [7:0]        mem_x [16];
	logic [7:0]        mem_y [16];
	logic [ADDR_W-1:0] stk_mem [STACK_ENTRIES];
	logic [ADDR_W-1:0] top_q;
	logic [CNT_W-1:0]  cnt_q;

	// Output register
	logic              out_valid_q;
	out_item_t         out_q;

	// Execute results
	logic              fire;
	logic              load;
	logic [ADDR_W-1:0] pc_adv;
	logic [ADDR_W-1:0] pc_n;
	logic [ADDR_W-1:0] idx_n;
	logic              wr;
	logic [7:0]        wv;
	logic              fl_wr;
	logic [7:0]        fl_v;
	logic              clr;
	status_t           st;
	logic              push;
	logic              pop;
	logic              skip;
	logic [8:0]        sum9;
	logic [7:0]        vf_d;
	logic              mem_wr;
	logic              byp_x;
	logic              byp_y;
	logic [7:0]        byp_val_x;
	logic [7:0]        byp_val_y;
	logic [SIDX_W-1:0] stk_rd_addr;

	assign fire      = valid_s2 && (!out_valid_q || out_ready);
	assign pop_ready = !valid_s2 || fire;
	assign load      = pop_valid && pop_ready;
	assign pc_adv    = pc_q + ADDR_W'(2);
	assign sum9      = {1'b0, vx_s2} + {1'b0, vy_s2};

	// Execute the instruction held in the operand stage
	always_comb begin
		pc_n  = pc_adv;
		idx_n = idx_q;
		wr    = 1'b0;
		wv    = '0;
		fl_wr = 1'b0;
		fl_v  = '0;
		clr   = 1'b0;
		st    = ST_DONE;
		push  = 1'b0;
		pop   = 1'b0;
		skip  = 1'b0;
		case (dec_s2.cls)
			OP_CLS: clr = 1'b1;
			OP_RET: begin
				if (cnt_q == '0) begin
					st = ST_UNDERFLOW;
				end else begin
					pop  = 1'b1;
					pc_n = top_q;
				end
			end
			OP_JP: pc_n = dec_s2.nnn;
			OP_CALL: begin
				if (cnt_q == CNT_W'(STACK_ENTRIES)) begin
					st = ST_OVERFLOW;
				end else begin
					push = 1'b1;
					pc_n = dec_s2.nnn;
				end
			end
			OP_SE_IMM:  skip = (vx_s2 == dec_s2.nnn[7:0]);
			OP_SNE_IMM: skip = (vx_s2 != dec_s2.nnn[7:0]);
			OP_SE_REG:  skip = (vx_s2 == vy_s2);
			OP_SNE_REG: skip = (vx_s2 != vy_s2);
			OP_LD_IMM: begin
				wr = 1'b1;
				wv = dec_s2.nnn[7:0];
			end
			OP_ADD_IMM: begin
				wr = 1'b1;
				wv = vx_s2 + dec_s2.nnn[7:0];
			end
			OP_ALU: begin
				wr = 1'b1;
				case (dec_s2.alu)
					ALU_MOV: wv = vy_s2;
					ALU_OR:  wv = vx_s2 | vy_s2;
					ALU_AND: wv = vx_s2 & vy_s2;
					ALU_XOR: wv = vx_s2 ^ vy_s2;
					ALU_ADD: begin
						wv    = sum9[7:0];
						fl_wr = 1'b1;
						fl_v  = {7'd0, sum9[8]};
					end
					ALU_SUB: begin
						wv    = vx_s2 - vy_s2;
						fl_wr = 1'b1;
						fl_v  = {7'd0, (vx_s2 >= vy_s2)};
					end
					ALU_SHR: begin
						wv    = {1'b0, vx_s2[7:1]};
						fl_wr = 1'b1;
						fl_v  = {7'd0, vx_s2[0]};
					end
					ALU_SUBN: begin
						wv    = vy_s2 - vx_s2;
						fl_wr = 1'b1;
						fl_v  = {7'd0, (vy_s2 >= vx_s2)};
					end
					ALU_SHL: begin
						wv    = {vx_s2[6:0], 1'b0};
						fl_wr = 1'b1;
						fl_v  = {7'd0, vx_s2[7]};
					end
					default: begin
						wr = 1'b0;
						st = ST_UNHANDLED;
					end
				endcase
			end
			OP_LD_I:  idx_n = dec_s2.nnn;
			OP_JP_V0: pc_n = dec_s2.nnn + {{(ADDR_W - 8){1'b0}}, v0_q};
			OP_RND: begin
				wr = 1'b1;
				wv = dec_s2.rnd & dec_s2.nnn[7:0];
			end
			default: st = ST_UNHANDLED;
		endcase
		if (skip)
			pc_n = pc_adv + ADDR_W'(2);
	end

	// VF is written first and VX second, so a write to VF as VX wins
	always_comb begin
		if (wr && dec_s2.x == REG_VF)
			vf_d = wv;
		else if (fl_wr)
			vf_d = fl_v;
		else
			vf_d = vf_q;
	end

	assign mem_wr = fire && wr && (dec_s2.x != REG_VF);

	// Forward the retiring write into operands read at the same edge
	always_comb begin
		byp_x     = 1'b0;
		byp_val_x = wv;
		byp_y     = 1'b0;
		byp_val_y = wv;
		if (pop_data.x == REG_VF) begin
			byp_x     = 1'b1;
			byp_val_x = fire ? vf_d : vf_q;
		end else if (mem_wr && dec_s2.x == pop_data.x) begin
			byp_x = 1'b1;
		end
		if (pop_data.y == REG_VF) begin
			byp_y     = 1'b1;
			byp_val_y = fire ? vf_d : vf_q;
		end else if (mem_wr && dec_s2.x == pop_data.y) begin
			byp_y = 1'b1;
		end
	end

	assign stk_rd_addr = SIDX_W'(cnt_q - CNT_W'(2));

	// Control state and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			pc_q        <= START_DEFAULT;
			idx_q       <= '0;
			v0_q        <= '0;
			vf_q        <= '0;
			vld_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (pop_ready)
				valid_s2 <= pop_valid;
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				pc_q <= cfg_data;
			end else if (fire) begin
				pc_q <= pc_n;
			end
			if (fire) begin
				idx_q <= idx_n;
				vf_q  <= vf_d;
				if (wr && dec_s2.x == REG_V0)
					v0_q <= wv;
				if (mem_wr)
					vld_q[dec_s2.x] <= 1'b1;
				if (push)
					cnt_q <= cnt_q + 1'b1;
				else if (pop)
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Register file copies, one per read port
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_x[dec_s2.x] <= wv;
			mem_y[dec_s2.x] <= wv;
		end
	end

	// Operand read with registered data
	always_ff @(posedge clk) begin
		if (load) begin
			dec_s2 <= pop_data;
			if (byp_x)
				vx_s2 <= byp_val_x;
			else if (!vld_q[pop_data.x])
				vx_s2 <= '0;
			else
				vx_s2 <= mem_x[pop_data.x];
			if (byp_y)
				vy_s2 <= byp_val_y;
			else if (!vld_q[pop_data.y])
				vy_s2 <= '0;
			else
				vy_s2 <= mem_y[pop_data.y];
		end
	end

	// Return stack with the top entry held in a register
	always_ff @(posedge clk) begin
		if (fire && push) begin
			stk_mem[cnt_q[SIDX_W-1:0]] <= pc_adv;
			top_q <= pc_adv;
		end else if (fire && pop) begin
			top_q <= stk_mem[stk_rd_addr];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.next_pc      <= pc_n;
			out_q.index_value  <= idx_n;
			out_q.write_enable <= wr;
			out_q.write_reg    <= wr ? dec_s2.x : 4'd0;
			out_q.write_value  <= wr ? wv : 8'd0;
			out_q.flag_value   <= vf_d;
			out_q.clear_screen <= clr;
			out_q.status       <= st;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/chip8_instruction_execute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// CHIP-8 instruction execution: classifying front end, request queue and
// execute back end with PC, I, V0..VF and the return stack.
// ----------------------------------------------------------------------------
//  channel  | ports                        | direction
//  ---------+------------------------------+-----------
//  input    | in_valid, in_ready, in_data   | request in
//  output   | out_valid, out_ready, out_data| result out
//  config   | cfg_we, cfg_data             | start address write
//
//  One instruction per cycle sustained while the output accepts results; a
//  request passes the front register (loaded at the accepting edge), the
//  queue, the operand read and the result register before its result is
//  valid. The execute step in the back end sets the rate.
//  Reset clears V0..VF, I and the stack depth and loads PC with 0x200; a
//  start address write loads PC at once. A stalled output backs up the
//  back end first, then the queue, then the input.
// ----------------------------------------------------------------------------
module chip8_instruction_execute #(
	parameter int STACK_ENTRIES = c8ie_pkg::STACK_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  c8ie_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output c8ie_pkg::out_item_t         out_data,
	input  logic                        cfg_we,
	input  logic [c8ie_pkg::ADDR_W-1:0] cfg_data
);
	import c8ie_pkg::*;

	logic push_valid;
	logic push_ready;
	dec_t push_data;
	logic pop_valid;
	logic pop_ready;
	dec_t pop_data;

	c8ie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	c8ie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	c8ie_back #(
		.STACK_ENTRIES (STACK_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- tb/sv/chip8_instruction_execute_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_execute_tb
// Self-checking bench for the CHIP-8 execute block. A local model of PC, I,
// V0..VF and the return stack predicts every result from the accepted
// requests. Directed tests cover each opcode, flag ordering, stack limits
// and PC wrap; random instruction streams then run under three idle mixes
// and several start addresses.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_tb;
	import c8ie_pkg::*;

	localparam int STACK_DEPTH   = STACK_ENTRIES_DEF;
	localparam int SETTLE_CYCLES = 6;     // a little beyond the pipeline latency
	localparam int STALL_LIMIT   = 1000;  // far beyond any run of 84% stalls
	localparam int MAX_REPORTS   = 40;

	// Instruction groups, coded by the top nibble
	localparam logic [3:0] GRP_SYS     = 4'h0;
	localparam logic [3:0] GRP_JP      = 4'h1;
	localparam logic [3:0] GRP_CALL    = 4'h2;
	localparam logic [3:0] GRP_SE_IMM  = 4'h3;
	localparam logic [3:0] GRP_SNE_IMM = 4'h4;
	localparam logic [3:0] GRP_SE_REG  = 4'h5;
	localparam logic [3:0] GRP_LD_IMM  = 4'h6;
	localparam logic [3:0] GRP_ADD_IMM = 4'h7;
	localparam logic [3:0] GRP_ALU     = 4'h8;
	localparam logic [3:0] GRP_SNE_REG = 4'h9;
	localparam logic [3:0] GRP_LD_I    = 4'hA;
	localparam logic [3:0] GRP_JP_V0   = 4'hB;
	localparam logic [3:0] GRP_RND     = 4'hC;
	localparam logic [3:0] GRP_DRAW    = 4'hD;
	localparam logic [3:0] GRP_KEY     = 4'hE;
	localparam logic [3:0] GRP_MISC    = 4'hF;

	localparam logic [15:0] INS_CLS = {GRP_SYS, 12'h0E0};
	localparam logic [15:0] INS_RET = {GRP_SYS, 12'h0EE};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we;
	logic [11:0] cfg_data;

	// Architectural state as the bench expects it
	logic [11:0] arch_pc;
	logic [11:0] arch_i;
	logic [7:0]  arch_v [16];
	logic [11:0] call_stack [STACK_DEPTH];
	int unsigned call_depth;

	out_item_t   awaited_results [$];
	int unsigned tx_idle_pct = 8;
	int unsigned rx_idle_pct = 84;
	int unsigned mismatch_count = 0;
	int unsigned result_count = 0;
	int unsigned stall_cycles = 0;

	chip8_instruction_execute #(
		.STACK_ENTRIES(STACK_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [15:0] ins_nnn(logic [3:0] grp, logic [11:0] nnn);
		return {grp, nnn};
	endfunction

	function automatic logic [15:0] ins_xnn(logic [3:0] grp, logic [3:0] x, logic [7:0] nn);
		return {grp, x, nn};
	endfunction

	function automatic logic [15:0] ins_xyn(logic [3:0] grp, logic [3:0] x, logic [3:0] y,
			logic [3:0] n);
		return {grp, x, y, n};
	endfunction

	// Execute one instruction on the expected state and build its result
	function automatic out_item_t execute_instr(in_item_t req);
		out_item_t   res;
		logic [3:0]  grp;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [11:0] nnn;
		logic [7:0]  nn;
		logic [7:0]  vx;
		logic [7:0]  vy;
		logic [8:0]  sum;
		logic        wr;
		logic        skip;

		res  = '0;
		grp  = req.instruction[15:12];
		x    = req.instruction[11:8];
		y    = req.instruction[7:4];
		nnn  = req.instruction[11:0];
		nn   = req.instruction[7:0];
		vx   = arch_v[x];
		vy   = arch_v[y];
		wr   = 1'b0;
		skip = 1'b0;
		res.status = ST_DONE;

		// fetch advance, wrapping at 12 bits
		arch_pc = arch_pc + 12'd2;

		case (grp)
			GRP_SYS: begin
				if (req.instruction == INS_CLS) begin
					res.clear_screen = 1'b1;
				end else if (req.instruction == INS_RET) begin
					if (call_depth == 0) begin
						res.status = ST_UNDERFLOW;
					end else begin
						call_depth--;
						arch_pc = call_stack[call_depth];
					end
				end else begin
					res.status = ST_UNHANDLED;
				end
			end
			GRP_JP: arch_pc = nnn;
			GRP_CALL: begin
				if (call_depth >= STACK_DEPTH) begin
					res.status = ST_OVERFLOW;
				end else begin
					call_stack[call_depth] = arch_pc;
					call_depth++;
					arch_pc = nnn;
				end
			end
			GRP_SE_IMM:  skip = (vx == nn);
			GRP_SNE_IMM: skip = (vx != nn);
			GRP_SE_REG:  skip = (vx == vy);
			GRP_SNE_REG: skip = (vx != vy);
			GRP_LD_IMM: begin
				arch_v[x] = nn;
				wr = 1'b1;
			end
			GRP_ADD_IMM: begin
				arch_v[x] = vx + nn;
				wr = 1'b1;
			end
			GRP_ALU: begin
				// VF first, then VX: with X = F the result overwrites the flag
				wr = 1'b1;
				case (req.instruction[3:0])
					ALU_MOV: arch_v[x] = vy;
					ALU_OR:  arch_v[x] = vx | vy;
					ALU_AND: arch_v[x] = vx & vy;
					ALU_XOR: arch_v[x] = vx ^ vy;
					ALU_ADD: begin
						sum = {1'b0, vx} + {1'b0, vy};
						arch_v[15] = {7'd0, sum[8]};
						arch_v[x] = sum[7:0];
					end
					ALU_SUB: begin
						arch_v[15] = (vx < vy) ? 8'd0 : 8'd1;
						arch_v[x] = vx - vy;
					end
					ALU_SHR: begin
						arch_v[15] = {7'd0, vx[0]};
						arch_v[x] = vx >> 1;
					end
					ALU_SUBN: begin
						arch_v[15] = (vy < vx) ? 8'd0 : 8'd1;
						arch_v[x] = vy - vx;
					end
					ALU_SHL: begin
						arch_v[15] = {7'd0, vx[7]};
						arch_v[x] = vx << 1;
					end
					default: begin
						wr = 1'b0;
						res.status = ST_UNHANDLED;
					end
				endcase
			end
			GRP_LD_I:  arch_i = nnn;
			GRP_JP_V0: arch_pc = nnn + {4'h0, arch_v[0]};
			GRP_RND: begin
				arch_v[x] = req.random_byte & nn;
				wr = 1'b1;
			end
			default: res.status = ST_UNHANDLED;
		endcase

		if (skip) begin
			arch_pc = arch_pc + 12'd2;
		end

		res.next_pc      = arch_pc;
		res.index_value  = arch_i;
		res.write_enable = wr;
		res.write_reg    = wr ? x : 4'h0;
		res.write_value  = wr ? arch_v[x] : 8'h00;
		res.flag_value   = arch_v[15];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatch_count++;
		// keep the log short when everything goes wrong
		if (mismatch_count <= MAX_REPORTS) begin
			$display("ERROR %0t result %0d: %s got 0x%0h expected 0x%0h", $time,
				result_count, what, got, want);
		end
	endtask

	// Send one request and record its expected result on acceptance
	task automatic issue_instr(logic [15:0] ins, logic [7:0] rnd = 8'h00);
		in_item_t req;

		req.instruction = ins;
		req.random_byte = rnd;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		awaited_results.insert(awaited_results.size(), execute_instr(req));
	endtask

	// Hold off requests until every awaited result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_start_address(logic [11:0] addr);
		drain_results();
		cfg_data <= addr;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
		arch_pc = addr;
	endtask

	function automatic logic [3:0] random_alu_code();
		case ($urandom_range(0, 9))
			0: return ALU_MOV;
			1: return ALU_OR;
			2: return ALU_AND;
			3: return ALU_XOR;
			4: return ALU_ADD;
			5: return ALU_SUB;
			6: return ALU_SHR;
			7: return ALU_SUBN;
			8: return ALU_SHL;
			default: return 4'($urandom_range(0, 15));
		endcase
	endfunction

	// Mostly well-formed instructions with random operands, some raw noise
	function automatic logic [15:0] random_instr();
		int unsigned pick;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [7:0]  nn;

		pick = $urandom_range(0, 99);
		x    = 4'($urandom_range(0, 15));
		y    = 4'($urandom_range(0, 15));
		nn   = 8'($urandom_range(0, 255));
		if (pick < 5)  return INS_CLS;
		if (pick < 13) return INS_RET;
		if (pick < 21) return ins_nnn(GRP_CALL, 12'($urandom_range(0, 4095)));
		if (pick < 25) return ins_nnn(GRP_JP, 12'($urandom_range(0, 4095)));
		if (pick < 29) return ins_xnn(GRP_SE_IMM, x, nn);
		if (pick < 33) return ins_xnn(GRP_SNE_IMM, x, nn);
		if (pick < 36) return ins_xyn(GRP_SE_REG, x, y, 4'($urandom_range(0, 15)));
		if (pick < 39) return ins_xyn(GRP_SNE_REG, x, y, 4'($urandom_range(0, 15)));
		if (pick < 51) return ins_xnn(GRP_LD_IMM, x, nn);
		if (pick < 57) return ins_xnn(GRP_ADD_IMM, x, nn);
		if (pick < 78) return ins_xyn(GRP_ALU, x, y, random_alu_code());
		if (pick < 82) return ins_nnn(GRP_LD_I, 12'($urandom_range(0, 4095)));
		if (pick < 86) return ins_nnn(GRP_JP_V0, 12'($urandom_range(0, 4095)));
		if (pick < 91) return ins_xnn(GRP_RND, x, nn);
		return 16'($urandom_range(0, 65535));
	endfunction

	// Reset values: PC from the default start address, all registers zero
	task automatic test_reset_defaults();
		issue_instr(ins_xnn(GRP_SE_IMM, 4'h0, 8'h00));
		issue_instr(INS_CLS);
		issue_instr(ins_xyn(GRP_ALU, 4'hF, 4'hE, ALU_ADD));
	endtask

	// Loads, adds, random loads and the whole 8XYn group, flag order with X = F
	task automatic test_alu_group();
		issue_instr(ins_xnn(GRP_LD_IMM, 4'h0, 8'hFF));
		issue_instr(ins_xnn(GRP_LD_IMM, 4'h1, 8'h01));
		issue_instr(ins_xyn(GRP_ALU, 4'h0, 4'h1, ALU_ADD));
		issue_instr(ins_xnn(GRP_LD_IMM, 4'hF, 8'h80));
		issue_instr(ins_xyn(GRP_ALU, 4'hF, 4'hF, ALU_ADD));
		issue_instr(ins_xnn(GRP_LD_IMM, 4'h2, 8'h33));
		issue_instr(ins_xnn(GRP_LD_IMM, 4'h3, 8'h55));
		issue_instr(ins_xyn(GRP_ALU, 4'h2, 4'h3, ALU_OR));
		issue_instr(ins_xyn(GRP_ALU, 4'h2, 4'h3, ALU_AND));
		issue_instr(ins_xyn(GRP_ALU, 4'h2, 4'h3, ALU_XOR));
		issue_instr(ins_xyn(GRP_ALU, 4'h2, 4'h3, ALU_SUB));
		issue_instr(ins_xyn(GRP_ALU, 4'h2, 4'h3, ALU_SUBN));
		issue_instr(ins_xyn(GRP_ALU, 4'h3, 4'h9, ALU_SHR));
		issue_instr(ins_xyn(GRP_ALU, 4'hF, 4'h0, ALU_SHL));
		issue_instr(ins_xyn(GRP_ALU, 4'h4, 4'h3, ALU_MOV));
		issue_instr(ins_xnn(GRP_ADD_IMM, 4'h4, 8'hFF));
		issue_instr(ins_xnn(GRP_RND, 4'h5, 8'hA5), 8'hFF);
		issue_instr(ins_xnn(GRP_RND, 4'h5, 8'h7F), 8'h80);
	endtask

	// Jumps, skips taken and not taken, set I, call and return
	task automatic test_flow_control();
		issue_instr(ins_xnn(GRP_SE_IMM, 4'h4, 8'h00));
		issue_instr(ins_xnn(GRP_SNE_IMM, 4'h4, 8'h00));
		issue_instr(ins_xyn(GRP_SE_REG, 4'h2, 4'h2, 4'hF));
		issue_instr(ins_xyn(GRP_SNE_REG, 4'h2, 4'h3, 4'h7));
		issue_instr(ins_nnn(GRP_LD_I, 12'hFFF));
		issue_instr(ins_xnn(GRP_LD_IMM, 4'h0, 8'h10));
		issue_instr(ins_nnn(GRP_JP_V0, 12'hFFF));
		issue_instr(ins_nnn(GRP_JP, 12'hABC));
		issue_instr(ins_nnn(GRP_CALL, 12'hFFE));
		issue_instr(INS_RET);
	endtask

	// Codes the block reports as not handled, with both extreme words
	task automatic test_unhandled();
		issue_instr(ins_nnn(GRP_SYS, 12'h000));
		issue_instr(ins_nnn(GRP_SYS, 12'h123));
		issue_instr(ins_xyn(GRP_ALU, 4'h1, 4'h2, 4'h8));
		issue_instr(ins_xyn(GRP_ALU, 4'h1, 4'h2, 4'hF));
		issue_instr(ins_xyn(GRP_DRAW, 4'h1, 4'h2, 4'h3));
		issue_instr(ins_xnn(GRP_KEY, 4'h1, 8'h9E));
		issue_instr(ins_nnn(GRP_MISC, 12'hFFF));
	endtask

	// Fetch advance and skip both wrap at the top of the address space
	task automatic test_pc_wrap();
		set_start_address(12'hFFE);
		issue_instr(ins_xnn(GRP_LD_IMM, 4'h0, 8'h00));
		set_start_address(12'hFFC);
		issue_instr(ins_xnn(GRP_SE_IMM, 4'h0, 8'h00));
		set_start_address(12'h000);
		issue_instr(INS_CLS);
	endtask

	// Fill the return stack, overflow it, then empty it and underflow it
	task automatic test_call_depth();
		for (int i = 0; i <= STACK_DEPTH; i++) begin
			issue_instr(ins_nnn(GRP_CALL, 12'($urandom_range(0, 4095))));
		end
		for (int i = 0; i <= STACK_DEPTH; i++) begin
			issue_instr(INS_RET);
		end
	endtask

	task automatic test_random_programs(int unsigned count, int unsigned tx_pct,
			int unsigned rx_pct, logic [11:0] start, bit hold_midway);
		set_start_address(start);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int unsigned i = 0; i < count; i++) begin
			// pause the sender until the pipeline has fully drained
			if (hold_midway && i == count / 2) begin
				drain_results();
			end
			issue_instr(random_instr(), 8'($urandom_range(0, 255)));
		end
	endtask

	// Random back-pressure on the result channel
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;

		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited", 16'(out_data.next_pc), '0);
			end else begin
				want = awaited_results.pop_front();
				if (out_data.next_pc !== want.next_pc)
					report_mismatch("next_pc", 16'(out_data.next_pc),
						16'(want.next_pc));
				if (out_data.index_value !== want.index_value)
					report_mismatch("index_value", 16'(out_data.index_value),
						16'(want.index_value));
				if (out_data.write_enable !== want.write_enable)
					report_mismatch("write_enable", 16'(out_data.write_enable),
						16'(want.write_enable));
				if (out_data.write_reg !== want.write_reg)
					report_mismatch("write_reg", 16'(out_data.write_reg),
						16'(want.write_reg));
				if (out_data.write_value !== want.write_value)
					report_mismatch("write_value", 16'(out_data.write_value),
						16'(want.write_value));
				if (out_data.flag_value !== want.flag_value)
					report_mismatch("flag_value", 16'(out_data.flag_value),
						16'(want.flag_value));
				if (out_data.clear_screen !== want.clear_screen)
					report_mismatch("clear_screen", 16'(out_data.clear_screen),
						16'(want.clear_screen));
				if (out_data.status !== want.status)
					report_mismatch("status", 16'(out_data.status), 16'(want.status));
			end
		end
	end

	// Drop the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= START_DEFAULT;
		arch_pc    = START_DEFAULT;
		arch_i     = '0;
		call_depth = 0;
		for (int i = 0; i < 16; i++) begin
			arch_v[i] = 8'h00;
		end

		// hold reset asserted before the first requests
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_alu_group();
		test_flow_control();
		test_unhandled();
		test_pc_wrap();
		test_call_depth();
		test_random_programs(125, 8, 84, 12'hFFF, 1'b0);
		test_random_programs(125, 84, 8, 12'($urandom_range(0, 4095)), 1'b1);
		test_random_programs(125, 0, 0, START_DEFAULT, 1'b0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
